/* design/cubic_bspline_point_smoother_top_assert.svh */
// assertion macros for the point smoother checker
`ifndef CUBIC_BSPLINE_POINT_SMOOTHER_TOP_ASSERT_SVH
`define CUBIC_BSPLINE_POINT_SMOOTHER_TOP_ASSERT_SVH

// same-cycle implication
`define CBPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CBPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/cbps_pkg.sv */
// shared types and constants for the cubic b-spline point smoother
package cbps_pkg;

  localparam int CoordW   = 32;
  localparam int StepW    = 7;
  localparam int IncrW    = 16;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 16;
  localparam int CoefW    = 36;
  localparam int AccW     = 38;
  localparam int TW       = IncrW + 1;
  localparam int ProdW    = AccW + TW;
  localparam int DivAW    = 18;
  localparam int DivBW    = 16;
  localparam int DefaultMaxSteps = 64;

  localparam logic [CfgIdxW-1:0] RegSteps = 1'd0;
  localparam logic [CfgIdxW-1:0] RegIncr  = 1'd1;

  localparam logic [StepW-1:0] StepsReset = 7'd30;
  localparam logic [IncrW-1:0] IncrReset  = 16'd2185;

  // six times the signed 32-bit range, bounds for the divide by six
  localparam logic signed [AccW-1:0] DivSpan = 38'sd12884901888;
  localparam logic [14:0] Recip3Hi = 15'd21845;
  localparam logic [19:0] Recip3Lo = 20'd699051;
  localparam int Recip3Shift = 21;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COEF,
    ST_MUL,
    ST_ADD,
    ST_DIV1,
    ST_DIV2,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic       load_point;
    logic       coef;
    logic       mul;
    logic       add;
    logic [1:0] step;
    logic       div1;
    logic       div2;
    logic       out_load;
    logic       out_last;
    logic       shift;
  } cmd_t;

  typedef struct packed {
    logic run;
  } status_t;

endpackage

/* design/cbps_point_if.sv */
// control point channel
interface cbps_point_if;
  import cbps_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] point_x;
  logic signed [CoordW-1:0] point_y;
  logic signed [CoordW-1:0] point_z;
  logic                     chain_start;
  modport source(output valid, point_x, point_y, point_z, chain_start, input ready);
  modport sink(input valid, point_x, point_y, point_z, chain_start, output ready);
endinterface

/* design/cbps_curve_if.sv */
// curve sample channel
interface cbps_curve_if;
  import cbps_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] curve_x;
  logic signed [CoordW-1:0] curve_y;
  logic signed [CoordW-1:0] curve_z;
  logic                     last_of_run;
  modport source(output valid, curve_x, curve_y, curve_z, last_of_run, input ready);
  modport sink(input valid, curve_x, curve_y, curve_z, last_of_run, output ready);
endinterface

/* design/cbps_ctrl.sv */
// controller: sequences coefficient setup, horner steps, divide and output
module cbps_ctrl #(
  parameter int MAX_STEPS = cbps_pkg::DefaultMaxSteps
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [cbps_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [cbps_pkg::CfgDataW-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  output logic                          out_valid,
  input  logic                          out_ready,
  input  cbps_pkg::status_t             status,
  output cbps_pkg::cmd_t                cmd
);
  import cbps_pkg::*;

  localparam int JW = $clog2(MAX_STEPS + 1);
  localparam logic [7:0] MaxN = 8'(MAX_STEPS);

  state_t           state, state_next;
  logic [1:0]       step;
  logic [JW-1:0]    j;
  logic [StepW-1:0] steps;
  logic [7:0]       n_raw, n_even, n_clip;
  logic [JW-1:0]    n;
  logic             last;
  logic             out_free;

  always_comb begin
    n_raw  = (steps == '0) ? 8'd1 : {1'b0, steps};
    n_even = n_raw + {7'd0, n_raw[0]};
    n_clip = (n_even > MaxN) ? MaxN : n_even;
    n      = n_clip[JW-1:0];
  end

  assign last     = (({1'b0, j} + (JW+1)'(1)) == {1'b0, n});
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid && status.run) state_next = ST_COEF;
      ST_COEF: state_next = ST_MUL;
      ST_MUL:  state_next = ST_ADD;
      ST_ADD:  state_next = (step == 2'd2) ? ST_DIV1 : ST_MUL;
      ST_DIV1: state_next = ST_DIV2;
      ST_DIV2: state_next = ST_OUT;
      ST_OUT:  if (out_free) state_next = last ? ST_IDLE : ST_MUL;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    cmd.step = step;
    unique case (state)
      ST_IDLE: begin
        in_ready       = 1'b1;
        cmd.load_point = in_valid;
      end
      ST_COEF: cmd.coef = 1'b1;
      ST_MUL:  cmd.mul = 1'b1;
      ST_ADD:  cmd.add = 1'b1;
      ST_DIV1: cmd.div1 = 1'b1;
      ST_DIV2: cmd.div2 = 1'b1;
      ST_OUT: begin
        cmd.out_load = out_free;
        cmd.out_last = last;
        cmd.shift    = out_free && last;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      j         <= '0;
      steps     <= StepsReset;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we && cfg_index == RegSteps) steps <= cfg_data[StepW-1:0];
      if (cmd.coef) begin
        j    <= '0;
        step <= '0;
      end
      if (cmd.add) step <= step + 2'd1;
      if (cmd.out_load) begin
        j    <= j + JW'(1);
        step <= '0;
      end
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

/* design/cbps_dp.sv */
// datapath: point window, coefficients, horner lanes, divide by six, output register
module cbps_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [cbps_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [cbps_pkg::CfgDataW-1:0]     cfg_data,
  input  logic signed [cbps_pkg::CoordW-1:0] point_x,
  input  logic signed [cbps_pkg::CoordW-1:0] point_y,
  input  logic signed [cbps_pkg::CoordW-1:0] point_z,
  input  logic                              chain_start,
  input  cbps_pkg::cmd_t                    cmd,
  output cbps_pkg::status_t                 status,
  output logic signed [cbps_pkg::CoordW-1:0] curve_x,
  output logic signed [cbps_pkg::CoordW-1:0] curve_y,
  output logic signed [cbps_pkg::CoordW-1:0] curve_z,
  output logic                              last_of_run
);
  import cbps_pkg::*;

  logic signed [CoordW-1:0] win [3][3];
  logic signed [CoordW-1:0] cur [3];
  logic signed [CoordW-1:0] pin [3];
  logic [1:0]               fill, fill_eff;
  logic [IncrW-1:0]         incr;
  logic [IncrW-1:0]         tt;
  logic [IncrW:0]           tt_sum;
  logic signed [TW-1:0]     ts;

  logic signed [CoefW-1:0]  c0 [3];
  logic signed [CoefW-1:0]  c1 [3];
  logic signed [CoefW-1:0]  c2 [3];
  logic signed [CoefW-1:0]  c3 [3];
  logic signed [AccW-1:0]   h [3];
  logic signed [ProdW-1:0]  prod [3];
  logic [DivAW-1:0]         da [3];
  logic [DivBW-1:0]         db [3];
  logic                     sat_hi [3];
  logic                     sat_lo [3];
  logic [32:0]              pa [3];
  logic [DivAW-1:0]         pq [3];
  logic signed [CoordW-1:0] res [3];

  assign pin[0]   = point_x;
  assign pin[1]   = point_y;
  assign pin[2]   = point_z;
  assign fill_eff = chain_start ? 2'd0 : fill;
  assign status.run = !chain_start && (fill == 2'd3);
  assign ts       = {1'b0, tt};
  assign tt_sum   = {1'b0, tt} + {1'b0, incr};

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      incr <= IncrReset;
    end else begin
      if (cfg_we && cfg_index == RegIncr) incr <= cfg_data[IncrW-1:0];
      if (cmd.load_point && fill_eff != 2'd3) fill <= fill_eff + 2'd1;
      else if (cmd.load_point) fill <= fill_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.coef) tt <= '0;
    else if (cmd.out_load) tt <= tt_sum[IncrW] ? '1 : tt_sum[IncrW-1:0];
    if (cmd.out_load) last_of_run <= cmd.out_last;
  end

  for (genvar c = 0; c < 3; c++) begin : g_lane
    logic signed [CoefW-1:0] p0, p1, p2, p3, d1, d2;
    logic signed [AccW-1:0]  mop, v, u, cadd;
    logic signed [ProdW-1:0] rnd;
    logic [AccW-1:0]         w;
    logic [DivAW:0]          abs;
    logic [DivAW+20:0]       qlo;
    logic [32:0]             qsum;

    always_comb begin
      p0   = CoefW'(win[0][c]);
      p1   = CoefW'(win[1][c]);
      p2   = CoefW'(win[2][c]);
      p3   = CoefW'(cur[c]);
      d1   = p2 - p0;
      d2   = p0 - (p1 <<< 1) + p2;
      mop  = (cmd.step == 2'd0) ? AccW'(c3[c]) : h[c];
      rnd  = (prod[c] + ProdW'(32768)) >>> 16;
      case (cmd.step)
        2'd0:    cadd = AccW'(c2[c]);
        2'd1:    cadd = AccW'(c1[c]);
        default: cadd = AccW'(c0[c]);
      endcase
      v    = h[c] + AccW'(3);
      u    = v + DivSpan;
      w    = AccW'(u) >> 1;
      abs  = {1'b0, da[c]} + (DivAW+1)'(db[c]);
      qlo  = (DivAW+21)'(abs) * (DivAW+21)'(Recip3Lo);
      qsum = pa[c] + 33'(pq[c]);
    end

    always_ff @(posedge clk) begin
      if (cmd.load_point) begin
        cur[c] <= pin[c];
        case (fill_eff)
          2'd0:    win[0][c] <= pin[c];
          2'd1:    win[1][c] <= pin[c];
          2'd2:    win[2][c] <= pin[c];
          default: ;
        endcase
      end
      if (cmd.shift) begin
        win[0][c] <= win[1][c];
        win[1][c] <= win[2][c];
        win[2][c] <= cur[c];
      end
      if (cmd.coef) begin
        c0[c] <= p0 + (p1 <<< 2) + p2;
        c1[c] <= (d1 <<< 1) + d1;
        c2[c] <= (d2 <<< 1) + d2;
        c3[c] <= p3 - p0 + (p1 <<< 1) + p1 - (p2 <<< 1) - p2;
      end
      if (cmd.mul) prod[c] <= mop * ts;
      if (cmd.add) h[c] <= AccW'(rnd) + cadd;
      if (cmd.div1) begin
        sat_lo[c] <= v < -DivSpan;
        sat_hi[c] <= v >= DivSpan;
        da[c]     <= w[DivAW+DivBW-1:DivBW];
        db[c]     <= w[DivBW-1:0];
      end
      if (cmd.div2) begin
        pa[c] <= 33'(da[c]) * 33'(Recip3Hi);
        pq[c] <= qlo[Recip3Shift+DivAW-1:Recip3Shift];
      end
      if (cmd.out_load) begin
        if (sat_lo[c]) res[c] <= {1'b1, {(CoordW-1){1'b0}}};
        else if (sat_hi[c]) res[c] <= {1'b0, {(CoordW-1){1'b1}}};
        else res[c] <= {~qsum[CoordW-1], qsum[CoordW-2:0]};
      end
    end
  end

  assign curve_x = res[0];
  assign curve_y = res[1];
  assign curve_z = res[2];

endmodule

/* design/cubic_bspline_point_smoother_top.sv */
// Uniform cubic B-spline point smoother. A point that only fills the four-point window is
// stored without producing samples. A point that completes a window yields n samples, n being
// the rounded step count: each sample runs three multiply and add passes through the one
// Horner multiplier of each coordinate lane, then two divide-by-six steps and an output load.
// The next point is taken while the last sample still waits.
module cubic_bspline_point_smoother_top #(
  parameter int MAX_STEPS = cbps_pkg::DefaultMaxSteps
) (
  input  logic                          clk,
  input  logic                          rst,
  cbps_point_if.sink                    points,
  cbps_curve_if.source                  curve,
  input  logic                          cfg_we,
  input  logic [cbps_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [cbps_pkg::CfgDataW-1:0] cfg_data
);
  import cbps_pkg::*;

  cmd_t    cmd;
  status_t status;

  cbps_ctrl #(.MAX_STEPS(MAX_STEPS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (points.valid),
    .in_ready  (points.ready),
    .out_valid (curve.valid),
    .out_ready (curve.ready),
    .status    (status),
    .cmd       (cmd)
  );

  cbps_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .point_x     (points.point_x),
    .point_y     (points.point_y),
    .point_z     (points.point_z),
    .chain_start (points.chain_start),
    .cmd         (cmd),
    .status      (status),
    .curve_x     (curve.curve_x),
    .curve_y     (curve.curve_y),
    .curve_z     (curve.curve_z),
    .last_of_run (curve.last_of_run)
  );

endmodule

/* design/cbps_checker.sv */
// port-level checker for the point smoother and its bind
`include "cubic_bspline_point_smoother_top_assert.svh"

module cbps_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            out_last,
  input logic signed [cbps_pkg::CoordW-1:0] curve_x,
  input logic signed [cbps_pkg::CoordW-1:0] curve_y,
  input logic signed [cbps_pkg::CoordW-1:0] curve_z
);
  `CBPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "sample dropped while stalled")
  `CBPS_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(curve_x) && $stable(curve_y) && $stable(curve_z) && $stable(out_last), "sample changed while stalled")
  `CBPS_ASSERT_NOW(a_busy_mid_run, out_valid && !out_last, !in_ready, "point taken mid run")
  `CBPS_ASSERT_NOW(a_reset_empty, $past(rst), !out_valid, "sample present after reset")
endmodule

bind cubic_bspline_point_smoother_top cbps_checker u_cbps_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (points.ready),
  .out_valid (curve.valid),
  .out_ready (curve.ready),
  .out_last  (curve.last_of_run),
  .curve_x   (curve.curve_x),
  .curve_y   (curve.curve_y),
  .curve_z   (curve.curve_z)
);

/* tb/sv/tb.sv */
// testbench for the cubic b-spline point smoother: directed table, then random chains checked against a predictor
`timescale 1ns / 100ps

module tb;
  import cbps_pkg::*;

  localparam int CycleLimit = 1000000;
  localparam int PhaseCount = 8;
  localparam int ItemsPerPhase = 9;
  localparam int MaxSteps = 64;
  localparam logic signed [CoordW-1:0] CoordMax = 32'sh7fffffff;
  localparam logic signed [CoordW-1:0] CoordMin = 32'sh80000000;

  typedef struct {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
    logic                     last;
  } sample_t;

  typedef struct {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
    bit                       cs;
    bit                       fixed;
    logic signed [CoordW-1:0] ex;
    logic signed [CoordW-1:0] ey;
    logic signed [CoordW-1:0] ez;
  } row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  cbps_point_if points_ch ();
  cbps_curve_if curve_ch ();

  cubic_bspline_point_smoother_top dut (
    .clk(clk),
    .rst(rst),
    .points(points_ch),
    .curve(curve_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // predictor state
  logic signed [CoordW-1:0] held [3][3];
  int unsigned held_fill;
  logic [StepW-1:0] steps_reg;
  logic [IncrW-1:0] incr_reg;

  sample_t expected_samples[$];
  int mismatches;
  int samples_seen;
  int points_sent;
  int cycles;
  int tx_idle_pct;
  int rx_idle_pct;

  row_t dir_rows [22] = '{
    '{0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 0, 1, 0, 0, 0},
    '{CoordMax, CoordMin, -1, 1, 0, 0, 0, 0},
    '{CoordMax, CoordMin, -1, 0, 0, 0, 0, 0},
    '{CoordMax, CoordMin, -1, 0, 0, 0, 0, 0},
    '{CoordMax, CoordMin, -1, 0, 1, CoordMax, CoordMin, -1},
    '{CoordMax, CoordMin, -1, 0, 1, CoordMax, CoordMin, -1},
    '{CoordMax, CoordMin, 0, 1, 0, 0, 0, 0},
    '{CoordMin, CoordMax, 0, 0, 0, 0, 0, 0},
    '{CoordMax, CoordMin, 0, 0, 0, 0, 0, 0},
    '{CoordMin, CoordMax, 0, 0, 0, 0, 0, 0},
    '{256, -512, 1000, 1, 0, 0, 0, 0},
    '{512, -256, -3000, 0, 0, 0, 0, 0},
    '{1024, 0, 77777, 0, 0, 0, 0, 0},
    '{-2048, 4096, -123456, 0, 0, 0, 0, 0},
    '{5, 6, 7, 1, 0, 0, 0, 0},
    '{-9, 33, 1 <<< 20, 1, 0, 0, 0, 0},
    '{100, -100, 50, 0, 0, 0, 0, 0},
    '{-300, 700, -1, 0, 0, 0, 0, 0},
    '{65536, -65536, 255, 0, 0, 0, 0, 0}
  };

  int phase_steps [PhaseCount] = '{0, 127, 1, 64, 5, 2, 11, 64};
  int phase_incr  [PhaseCount] = '{0, 65535, 32768, 1024, 13107, 65535, 5958, 1};

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    curve_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  function automatic int unsigned sample_count();
    int unsigned n;
    n = (steps_reg == 0) ? 1 : steps_reg;
    if (n[0]) n++;
    if (n > MaxSteps) n = MaxSteps;
    return n;
  endfunction

  function automatic logic signed [CoordW-1:0] spline_coord(longint p0, longint p1,
                                                            longint p2, longint p3,
                                                            longint t);
    longint c0, c1, c2, c3, h, q;
    c0 = p0 + 4 * p1 + p2;
    c1 = 3 * (p2 - p0);
    c2 = 3 * (p0 - 2 * p1 + p2);
    c3 = -p0 + 3 * p1 - 3 * p2 + p3;
    h = c3;
    h = ((h * t + 32768) >>> 16) + c2;
    h = ((h * t + 32768) >>> 16) + c1;
    h = ((h * t + 32768) >>> 16) + c0;
    h = h + 3;
    q = h / 6;
    if ((h % 6) < 0) q = q - 1;
    if (q > longint'(CoordMax)) q = CoordMax;
    if (q < longint'(CoordMin)) q = CoordMin;
    return q[CoordW-1:0];
  endfunction

  // update the window and queue the samples this point causes
  task automatic predict_point(row_t r);
    logic signed [CoordW-1:0] cur [3];
    int unsigned n;
    longint tt;
    sample_t s;
    cur[0] = r.x;
    cur[1] = r.y;
    cur[2] = r.z;
    if (r.cs) begin
      held_fill = 0;
      for (int i = 0; i < 3; i++) for (int c = 0; c < 3; c++) held[i][c] = '0;
    end
    if (held_fill < 3) begin
      for (int c = 0; c < 3; c++) held[held_fill][c] = cur[c];
      held_fill++;
    end else begin
      n = sample_count();
      for (int unsigned j = 0; j < n; j++) begin
        tt = longint'(j) * longint'(incr_reg);
        if (tt > 65535) tt = 65535;
        if (r.fixed) begin
          s.x = r.ex;
          s.y = r.ey;
          s.z = r.ez;
        end else begin
          s.x = spline_coord(held[0][0], held[1][0], held[2][0], cur[0], tt);
          s.y = spline_coord(held[0][1], held[1][1], held[2][1], cur[1], tt);
          s.z = spline_coord(held[0][2], held[1][2], held[2][2], cur[2], tt);
        end
        s.last = (j + 1 == n);
        expected_samples.push_back(s);
      end
      for (int c = 0; c < 3; c++) begin
        held[0][c] = held[1][c];
        held[1][c] = held[2][c];
        held[2][c] = cur[c];
      end
    end
  endtask

  // called at a falling edge, returns at a falling edge after the transaction
  task automatic send_point(row_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      points_ch.valid <= 1'b0;
      @(negedge clk);
    end
    points_ch.valid <= 1'b1;
    points_ch.point_x <= r.x;
    points_ch.point_y <= r.y;
    points_ch.point_z <= r.z;
    points_ch.chain_start <= r.cs;
    @(posedge clk);
    while (!points_ch.ready) @(posedge clk);
    predict_point(r);
    points_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    points_ch.valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == RegSteps) steps_reg = data[StepW-1:0];
    else if (idx == RegIncr) incr_reg = data[IncrW-1:0];
  endtask

  function automatic logic signed [CoordW-1:0] rand_coord();
    case ($urandom_range(9))
      0: return CoordMax;
      1: return CoordMin;
      2, 3: return $urandom;
      default: return $signed($urandom_range(0, 1 << 20)) - (1 <<< 19);
    endcase
  endfunction

  function automatic row_t rand_row(bit cs);
    row_t r;
    r.x = rand_coord();
    r.y = rand_coord();
    r.z = rand_coord();
    r.cs = cs;
    r.fixed = 0;
    r.ex = 0;
    r.ey = 0;
    r.ez = 0;
    return r;
  endfunction

  always @(posedge clk) begin
    sample_t e;
    if (!rst && curve_ch.valid && curve_ch.ready) begin
      samples_seen++;
      if (expected_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected sample x=%0d y=%0d z=%0d last=%0b", curve_ch.curve_x,
                   curve_ch.curve_y, curve_ch.curve_z, curve_ch.last_of_run);
      end else begin
        e = expected_samples.pop_front();
        if (curve_ch.curve_x !== e.x || curve_ch.curve_y !== e.y ||
            curve_ch.curve_z !== e.z || curve_ch.last_of_run !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("sample mismatch: expected x=%0d y=%0d z=%0d last=%0b, got x=%0d y=%0d z=%0d last=%0b",
                     e.x, e.y, e.z, e.last, curve_ch.curve_x, curve_ch.curve_y,
                     curve_ch.curve_z, curve_ch.last_of_run);
        end
      end
    end
  end

  initial begin
    int items;
    int len;
    rst = 1'b1;
    cycles = 0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    points_ch.valid = 1'b0;
    points_ch.point_x = '0;
    points_ch.point_y = '0;
    points_ch.point_z = '0;
    points_ch.chain_start = 1'b0;
    curve_ch.ready = 1'b0;
    mismatches = 0;
    samples_seen = 0;
    points_sent = 0;
    tx_idle_pct = 32;
    rx_idle_pct = 70;
    held_fill = 0;
    for (int i = 0; i < 3; i++) for (int c = 0; c < 3; c++) held[i][c] = '0;
    steps_reg = StepsReset;
    incr_reg = IncrReset;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) send_point(dir_rows[i]);

    for (int p = 0; p < PhaseCount; p++) begin
      if (p >= 6) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else if (p >= 3) begin
        tx_idle_pct = 70;
        rx_idle_pct = 32;
      end
      wait_drained();
      write_reg(RegSteps, CfgDataW'(phase_steps[p]) | (CfgDataW'($urandom) & 16'hff80));
      write_reg(RegIncr, CfgDataW'(phase_incr[p]));
      items = 0;
      while (items < ItemsPerPhase) begin
        if ($urandom_range(9) < 8) begin
          len = $urandom_range(4, 7);
          for (int k = 0; k < len; k++) send_point(rand_row(k == 0));
          items += len;
        end else begin
          send_point(rand_row($urandom_range(1)));
          items++;
        end
      end
    end

    points_ch.valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("covered %0d points and %0d samples over %0d register settings",
             points_sent, samples_seen, PhaseCount + 1);
    $display("settings included zero and over-range step counts and zero and full increments");
    if (mismatches == 0 && expected_samples.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
